// ===== rtl/text_console_writer_assert.svh =====
// Assertion helpers used by the console engine.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TCW_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tcw assertion failed");

// Next-cycle implication, checked out of reset.
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tcw assertion failed");

`endif

// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

    typedef enum logic [1:0] {
        MODE_PUT   = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_SET   = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CLEAR,
        S_SCROLL,
        S_DONE
    } t_state;

    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam int CELL_W = 16;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  char_code;
        logic [6:0]  new_column;
        logic [4:0]  new_row;
        logic [10:0] cell_address;
    } t_item;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [15:0] cell_data;
        logic        scrolled;
    } t_res;

endpackage

// ===== rtl/tcw_cell_ram.sv =====
module tcw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [tcw_pkg::CELL_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [tcw_pkg::CELL_W-1:0] o_rdata
);

    logic [tcw_pkg::CELL_W-1:0] r_mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tcw_engine.sv =====
`include "text_console_writer_assert.svh"

module tcw_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tcw_pkg::t_item i_item,
    input  logic [7:0]     i_color,
    output logic           o_res_valid,
    input  logic           i_res_take,
    output tcw_pkg::t_res  o_res
);

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int AW       = $clog2(CELLS);
    localparam int CW       = $clog2(CELLS + 1);
    localparam int CLW      = $clog2(COLUMNS);
    localparam int RW       = $clog2(ROWS);
    localparam int PW       = (AW > 11) ? AW : 11;
    localparam int COPY_END = CELLS - COLUMNS;
    localparam logic [CLW-1:0] LAST_COL     = CLW'(COLUMNS - 1);
    localparam logic [RW-1:0]  LAST_ROW     = RW'(ROWS - 1);
    localparam logic [AW-1:0]  LAST_ROW_POS = AW'((ROWS - 1) * COLUMNS);

    tcw_pkg::t_state r_state, n_state;
    logic [CLW-1:0]  r_col, n_col;
    logic [RW-1:0]   r_row, n_row;
    logic [AW-1:0]   r_pos, n_pos;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [15:0]     r_data, n_data;
    logic            r_scr, n_scr;

    logic                       mem_we, mem_re;
    logic [AW-1:0]              mem_waddr, mem_raddr;
    logic [tcw_pkg::CELL_W-1:0] mem_wdata, mem_rdata;

    logic            accept;
    logic            at_last_col, at_last_row;
    logic            is_special, put_scroll, addr_ok;
    logic [15:0]     blank;
    logic [RW-1:0]   set_row;
    logic [CLW-1:0]  set_col;
    logic [PW-1:0]   pos_ext;

    tcw_cell_ram #(
        .DEPTH(CELLS),
        .AW   (AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign accept      = i_valid && (r_state == tcw_pkg::S_IDLE);
    assign at_last_col = (r_col == LAST_COL);
    assign at_last_row = (r_row == LAST_ROW);
    assign blank       = {i_color, tcw_pkg::CH_SPACE};
    assign addr_ok     = (32'(i_item.cell_address) < CELLS);
    assign is_special  = (i_item.char_code == tcw_pkg::CH_NEWLINE)
                      || (i_item.char_code == tcw_pkg::CH_BACKSPACE)
                      || (i_item.char_code == tcw_pkg::CH_RETURN);
    assign put_scroll  = at_last_row
                      && ((i_item.char_code == tcw_pkg::CH_NEWLINE)
                          || (!is_special && at_last_col));
    assign set_col = (32'(i_item.new_column) > COLUMNS - 1) ? LAST_COL
                                                            : CLW'(i_item.new_column);
    assign set_row = (32'(i_item.new_row) > ROWS - 1) ? LAST_ROW : RW'(i_item.new_row);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tcw_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_item.mode)
                        tcw_pkg::MODE_PUT:   n_state = put_scroll ? tcw_pkg::S_SCROLL
                                                                  : tcw_pkg::S_DONE;
                        tcw_pkg::MODE_CLEAR: n_state = tcw_pkg::S_CLEAR;
                        tcw_pkg::MODE_SET:   n_state = tcw_pkg::S_DONE;
                        tcw_pkg::MODE_READ:  n_state = addr_ok ? tcw_pkg::S_READ
                                                               : tcw_pkg::S_DONE;
                        default:             n_state = tcw_pkg::S_DONE;
                    endcase
                end
            end
            tcw_pkg::S_READ:   n_state = tcw_pkg::S_DONE;
            tcw_pkg::S_CLEAR: begin
                if (r_cnt == CW'(CELLS - 1)) n_state = tcw_pkg::S_DONE;
            end
            tcw_pkg::S_SCROLL: begin
                if (r_cnt == CW'(CELLS)) n_state = tcw_pkg::S_DONE;
            end
            tcw_pkg::S_DONE: begin
                if (i_res_take) n_state = tcw_pkg::S_IDLE;
            end
            default: n_state = tcw_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_pos     = r_pos;
        n_cnt     = r_cnt;
        n_data    = r_data;
        n_scr     = r_scr;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = blank;
        mem_re    = 1'b0;
        mem_raddr = AW'(i_item.cell_address);
        case (r_state)
            tcw_pkg::S_IDLE: begin
                if (accept) begin
                    n_data = '0;
                    n_scr  = 1'b0;
                    n_cnt  = '0;
                    case (i_item.mode)
                        tcw_pkg::MODE_PUT: begin
                            if (i_item.char_code == tcw_pkg::CH_NEWLINE) begin
                                n_col = '0;
                                if (at_last_row) begin
                                    n_pos = LAST_ROW_POS;
                                    n_scr = 1'b1;
                                end else begin
                                    n_row = r_row + 1'b1;
                                    n_pos = AW'(r_pos - AW'(r_col) + AW'(COLUMNS));
                                end
                            end else if (i_item.char_code == tcw_pkg::CH_BACKSPACE) begin
                                if (r_col != '0 || r_row != '0) begin
                                    mem_we    = 1'b1;
                                    mem_waddr = r_pos - 1'b1;
                                    n_pos     = r_pos - 1'b1;
                                    if (r_col != '0) begin
                                        n_col = r_col - 1'b1;
                                    end else begin
                                        n_col = LAST_COL;
                                        n_row = r_row - 1'b1;
                                    end
                                end
                            end else if (i_item.char_code == tcw_pkg::CH_RETURN) begin
                                n_col = '0;
                                n_pos = AW'(r_pos - AW'(r_col));
                            end else begin
                                mem_we    = 1'b1;
                                mem_wdata = {i_color, i_item.char_code};
                                if (at_last_col) begin
                                    n_col = '0;
                                    if (at_last_row) begin
                                        n_pos = LAST_ROW_POS;
                                        n_scr = 1'b1;
                                    end else begin
                                        n_row = r_row + 1'b1;
                                        n_pos = r_pos + 1'b1;
                                    end
                                end else begin
                                    n_col = r_col + 1'b1;
                                    n_pos = r_pos + 1'b1;
                                end
                            end
                        end
                        tcw_pkg::MODE_CLEAR: begin
                            n_col = '0;
                            n_row = '0;
                            n_pos = '0;
                        end
                        tcw_pkg::MODE_SET: begin
                            n_col = set_col;
                            n_row = set_row;
                            n_pos = AW'(32'(set_row) * COLUMNS + 32'(set_col));
                        end
                        tcw_pkg::MODE_READ: begin
                            mem_re = addr_ok;
                        end
                        default: ;
                    endcase
                end
            end
            tcw_pkg::S_READ: begin
                n_data = mem_rdata;
            end
            tcw_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt[AW-1:0];
                n_cnt     = r_cnt + 1'b1;
            end
            tcw_pkg::S_SCROLL: begin
                // read the cell one row down, write it back in the next cycle
                mem_re    = (32'(r_cnt) < COPY_END);
                mem_raddr = AW'(r_cnt + CW'(COLUMNS));
                mem_we    = (r_cnt != '0);
                mem_waddr = AW'(r_cnt - 1'b1);
                mem_wdata = (32'(r_cnt) <= COPY_END) ? mem_rdata : blank;
                n_cnt     = r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_scr   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_scr   <= n_scr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign pos_ext          = PW'(r_pos);
    assign o_ready          = (r_state == tcw_pkg::S_IDLE);
    assign o_res_valid      = (r_state == tcw_pkg::S_DONE);
    assign o_res.cursor_pos = pos_ext[10:0];
    assign o_res.cell_data  = r_data;
    assign o_res.scrolled   = r_scr;

    `TCW_ASSERT_SAME(a_pos_track, r_state == tcw_pkg::S_IDLE, 32'(r_pos) == 32'(r_row) * COLUMNS + 32'(r_col))
    `TCW_ASSERT_SAME(a_cursor_range, 1'b1, (r_col <= LAST_COL) && (r_row <= LAST_ROW))
    `TCW_ASSERT_SAME(a_no_rw_clash, mem_we && mem_re, mem_waddr != mem_raddr)
    `TCW_ASSERT_NEXT(a_leave_idle, accept, r_state != tcw_pkg::S_IDLE)

endmodule

// ===== rtl/text_console_writer.sv =====
// Channel   Dir  Fields (low bit up)                                      Accepted when
// s_axis    in   tdata: char_code, new_column, new_row, cell_address;     tvalid & tready
//                tuser: mode
// m_axis    out  tdata: cursor_pos, cell_data; tuser: scrolled           tvalid & tready
// apb       in   text_color at address 0                                 psel&penable&pwrite
//
// Put, backspace, return and set cursor go from accept straight to the result; read cell
// passes through a read state first, unless the address is off screen.
// Clear and a put that scrolls sweep the cell RAM one cell per cycle (one read port,
// one write port).
// One item is in work at a time; a new item is taken while the last result waits.
// Reset clears the cursor and sets text_color to 0x07; the cell store is not cleared.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // char_code[7:0], new_column[14:8], new_row[19:15],
                                        // cell_address[30:20]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // cursor_pos[10:0], cell_data[26:11]
    output logic [0:0]  m_axis_tuser,   // scrolled[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_TEXT_COLOR = 1'b0;

    logic [7:0]     r_color;
    logic           r_out_valid;
    tcw_pkg::t_res  r_out;
    tcw_pkg::t_item item;
    tcw_pkg::t_res  res;
    logic           res_valid;
    logic           res_take;
    logic           cfg_wr;

    assign item.mode         = tcw_pkg::t_mode'(s_axis_tuser);
    assign item.char_code    = s_axis_tdata[7:0];
    assign item.new_column   = s_axis_tdata[14:8];
    assign item.new_row      = s_axis_tdata[19:15];
    assign item.cell_address = s_axis_tdata[30:20];

    tcw_engine #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_item     (item),
        .i_color    (r_color),
        .o_res_valid(res_valid),
        .i_res_take (res_take),
        .o_res      (res)
    );

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_TEXT_COLOR) ? {24'd0, r_color} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= 8'h07;
        end else if (cfg_wr && paddr[2] == REG_TEXT_COLOR) begin
            r_color <= pwdata[7:0];
        end
    end

    // Output register: load when empty or being drained
    assign res_take = res_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.cell_data, r_out.cursor_pos};
    assign m_axis_tuser  = r_out.scrolled;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELL_COUNT  = COLUMNS * ROWS;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE      = 2100;
    localparam int HOLD_OFF    = 300;

    localparam logic [2:0] ADDR_TEXT_COLOR = 3'd0;

    // Screen, cursor and color tracker; holds the results still owed by the block.
    class console_scoreboard;
        logic [15:0]    cells [0:CELL_COUNT-1];
        int unsigned    col;
        int unsigned    row;
        logic [7:0]     color;
        tcw_pkg::t_res  pending_results[$];
        int unsigned    results_seen;
        int unsigned    errors;

        function new();
            foreach (cells[i]) cells[i] = '0;
            col = 0;
            row = 0;
            color = 8'h07;
            results_seen = 0;
            errors = 0;
        endfunction

        function void set_color(logic [7:0] value);
            color = value;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void roll_screen();
            for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
                cells[i] = cells[i + COLUMNS];
            for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                cells[i] = {color, tcw_pkg::CH_SPACE};
        endfunction

        function bit put_char(logic [7:0] ch);
            if (ch == tcw_pkg::CH_NEWLINE) begin
                col = 0;
                row++;
            end else if (ch == tcw_pkg::CH_BACKSPACE) begin
                if (col > 0) begin
                    col--;
                    cells[row * COLUMNS + col] = {color, tcw_pkg::CH_SPACE};
                end else if (row > 0) begin
                    row--;
                    col = COLUMNS - 1;
                    cells[row * COLUMNS + col] = {color, tcw_pkg::CH_SPACE};
                end
            end else if (ch == tcw_pkg::CH_RETURN) begin
                col = 0;
            end else begin
                cells[row * COLUMNS + col] = {color, ch};
                col++;
            end
            if (col >= COLUMNS) begin
                col = 0;
                row++;
            end
            if (row >= ROWS) begin
                roll_screen();
                row = ROWS - 1;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_item(tcw_pkg::t_item it);
            tcw_pkg::t_res want;
            want = '0;
            case (it.mode)
                tcw_pkg::MODE_PUT: begin
                    want.scrolled = put_char(it.char_code);
                end
                tcw_pkg::MODE_CLEAR: begin
                    foreach (cells[i]) cells[i] = {color, tcw_pkg::CH_SPACE};
                    col = 0;
                    row = 0;
                end
                tcw_pkg::MODE_SET: begin
                    col = (it.new_column > COLUMNS - 1) ? COLUMNS - 1 : it.new_column;
                    row = (it.new_row > ROWS - 1) ? ROWS - 1 : it.new_row;
                end
                default: begin
                    if (it.cell_address < CELL_COUNT)
                        want.cell_data = cells[it.cell_address];
                end
            endcase
            want.cursor_pos = 11'(row * COLUMNS + col);
            pending_results.push_back(want);
        endfunction

        task check_result(tcw_pkg::t_res got);
            tcw_pkg::t_res want;
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none expected",
                                          results_seen));
                return;
            end
            want = pending_results.pop_front();
            if (got.cursor_pos !== want.cursor_pos)
                report_mismatch($sformatf("result %0d cursor_pos got %0d expected %0d",
                                          results_seen, got.cursor_pos, want.cursor_pos));
            if (got.cell_data !== want.cell_data)
                report_mismatch($sformatf("result %0d cell_data got %h expected %h",
                                          results_seen, got.cell_data, want.cell_data));
            if (got.scrolled !== want.scrolled)
                report_mismatch($sformatf("result %0d scrolled got %b expected %b",
                                          results_seen, got.scrolled, want.scrolled));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // char_code, new_column, new_row, cell_address
    logic [1:0]  s_axis_tuser;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // cursor_pos, cell_data
    logic [0:0]  m_axis_tuser;   // scrolled
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    console_scoreboard board;
    bit                idle_on;
    int                hold_cycles;
    int                quiet_cycles;

    text_console_writer #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Monitor both streams and keep the watchdog going.
    always @(posedge i_clk) begin
        tcw_pkg::t_item in_item;
        tcw_pkg::t_res  out_res;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                in_item.mode         = tcw_pkg::t_mode'(s_axis_tuser);
                in_item.char_code    = s_axis_tdata[7:0];
                in_item.new_column   = s_axis_tdata[14:8];
                in_item.new_row      = s_axis_tdata[19:15];
                in_item.cell_address = s_axis_tdata[30:20];
                board.note_item(in_item);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                out_res.cursor_pos = m_axis_tdata[10:0];
                out_res.cell_data  = m_axis_tdata[26:11];
                out_res.scrolled   = m_axis_tuser[0];
                board.check_result(out_res);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (psel && penable && pready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus a long hold-off when requested.
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            if (hold_cycles > 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = idle_on ? $urandom_range(0, 4) : 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready)) @(posedge i_clk);
        end
    end

    // Leave tvalid high after the handshake; stop_sending drops it.
    task automatic send_item(tcw_pkg::t_item it);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, it.cell_address, it.new_row, it.new_column, it.char_code};
        s_axis_tuser  <= it.mode;
        @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready)) @(posedge i_clk);
    endtask

    task automatic send_fields(tcw_pkg::t_mode m, logic [7:0] ch, logic [6:0] c,
                               logic [4:0] r, logic [10:0] a);
        tcw_pkg::t_item it;
        it.mode         = m;
        it.char_code    = ch;
        it.new_column   = c;
        it.new_row      = r;
        it.cell_address = a;
        send_item(it);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_color(logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TEXT_COLOR;
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_color(value);
        @(posedge i_clk);
    endtask

    // Mostly text with line control, cursor moves that favor the bottom edge, reads, clears.
    function automatic tcw_pkg::t_item random_item();
        tcw_pkg::t_item it;
        int             pick;
        int             ch_pick;
        it.mode         = tcw_pkg::t_mode'($urandom_range(0, 3));
        it.char_code    = 8'($urandom_range(0, 255));
        it.new_column   = 7'($urandom_range(0, 127));
        it.new_row      = 5'($urandom_range(0, 31));
        it.cell_address = 11'($urandom_range(0, 2047));
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            it.mode = tcw_pkg::MODE_PUT;
            ch_pick = $urandom_range(0, 99);
            if (ch_pick < 15)
                it.char_code = tcw_pkg::CH_NEWLINE;
            else if (ch_pick < 23)
                it.char_code = tcw_pkg::CH_BACKSPACE;
            else if (ch_pick < 30)
                it.char_code = tcw_pkg::CH_RETURN;
        end else if (pick < 66) begin
            it.mode = tcw_pkg::MODE_SET;
            if ($urandom_range(0, 1)) begin
                it.new_column = 7'($urandom_range(COLUMNS - 10, 127));
                it.new_row    = 5'($urandom_range(ROWS - 2, 31));
            end
        end else if (pick < 95) begin
            it.mode = tcw_pkg::MODE_READ;
            if ($urandom_range(0, 1))
                it.cell_address = 11'($urandom_range(0, CELL_COUNT - 1));
        end else begin
            it.mode = tcw_pkg::MODE_CLEAR;
        end
        return it;
    endfunction

    task automatic run_random(int count, int pause_at);
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) begin
                stop_sending();
                wait_drained();
            end
            send_item(random_item());
        end
        stop_sending();
    endtask

    initial begin
        board = new();
        idle_on       = 1'b1;
        hold_cycles   = 0;
        quiet_cycles  = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset color first, the clear makes every cell readable.
        send_fields(tcw_pkg::MODE_CLEAR, 8'h00, 7'd0, 5'd0, 11'd0);
        send_fields(tcw_pkg::MODE_READ, 8'h00, 7'd0, 5'd0, 11'd0);
        send_fields(tcw_pkg::MODE_PUT, 8'h41, 7'd0, 5'd0, 11'd0);
        send_fields(tcw_pkg::MODE_PUT, 8'hFF, 7'd0, 5'd0, 11'd0);
        send_fields(tcw_pkg::MODE_PUT, 8'h00, 7'd0, 5'd0, 11'd0);
        send_fields(tcw_pkg::MODE_PUT, 8'h80, 7'd0, 5'd0, 11'd0);
        send_fields(tcw_pkg::MODE_READ, 8'h00, 7'd0, 5'd0, 11'd1);
        send_fields(tcw_pkg::MODE_PUT, tcw_pkg::CH_BACKSPACE, 7'd0, 5'd0, 11'd0);
        send_fields(tcw_pkg::MODE_READ, 8'h00, 7'd0, 5'd0, 11'd3);
        send_fields(tcw_pkg::MODE_SET, 8'h00, 7'd0, 5'd0, 11'd0);
        send_fields(tcw_pkg::MODE_PUT, tcw_pkg::CH_BACKSPACE, 7'd0, 5'd0, 11'd0);
        send_fields(tcw_pkg::MODE_SET, 8'h00, 7'd127, 5'd31, 11'd0);
        send_fields(tcw_pkg::MODE_READ, 8'h00, 7'd0, 5'd0, 11'd1999);
        send_fields(tcw_pkg::MODE_READ, 8'h00, 7'd0, 5'd0, 11'd2000);
        send_fields(tcw_pkg::MODE_READ, 8'h00, 7'd0, 5'd0, 11'd2047);
        send_fields(tcw_pkg::MODE_PUT, 8'h5A, 7'd0, 5'd0, 11'd0);
        send_fields(tcw_pkg::MODE_READ, 8'h00, 7'd0, 5'd0, 11'd1919);
        send_fields(tcw_pkg::MODE_SET, 8'h00, 7'd0, 5'd5, 11'd0);
        send_fields(tcw_pkg::MODE_PUT, tcw_pkg::CH_BACKSPACE, 7'd0, 5'd0, 11'd0);
        send_fields(tcw_pkg::MODE_READ, 8'h00, 7'd0, 5'd0, 11'd399);
        send_fields(tcw_pkg::MODE_PUT, tcw_pkg::CH_RETURN, 7'd0, 5'd0, 11'd0);
        send_fields(tcw_pkg::MODE_SET, 8'h00, 7'd10, 5'd24, 11'd0);
        send_fields(tcw_pkg::MODE_PUT, tcw_pkg::CH_NEWLINE, 7'd0, 5'd0, 11'd0);
        send_fields(tcw_pkg::MODE_READ, 8'h00, 7'd0, 5'd0, 11'd1920);
        stop_sending();
        wait_drained();

        write_color(8'h00);
        run_random(40, 20);
        wait_drained();

        write_color(8'hFF);
        run_random(40, -1);
        wait_drained();

        // Back-to-back traffic with a long receiver hold-off to fill the block.
        write_color(8'($urandom_range(1, 254)));
        idle_on = 1'b0;
        hold_cycles = HOLD_OFF;
        run_random(36, -1);

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (board.pending_results.size() != 0)
            board.report_mismatch($sformatf("%0d expected results never arrived",
                                            board.pending_results.size()));
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
